[hdl/srsw_pkg.sv]
// Shared types and constants of the selective-repeat send window.
// No dependencies; the other files, bar srsw_checker, use this package by scoped names.
`default_nettype none

package srsw_pkg;

	// Sequence numbers and window sizes.
	localparam int SEQ_W = 16;
	localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

	// Configuration register widths and port width.
	localparam int TOTAL_W = 16;
	localparam int LIMIT_W = 16;
	localparam int STEP_W = 8;
	localparam int DIVISOR_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	// Stream payload widths.
	localparam int IN_DATA_W = 24;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 56;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_START_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_INCREASE_STEP = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DECREASE_DIVISOR = 2'd3;

	// Event codes carried on the input tuser.
	typedef enum logic [1:0] {
		FUNC_SENT = 2'd0,
		FUNC_ACK = 2'd1,
		FUNC_TIMEOUT = 2'd2,
		FUNC_CONGESTION = 2'd3
	} func_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SLIDE,
		ST_GROW,
		ST_DIV,
		ST_LAST,
		ST_OUT
	} state_t;

	// Control broadcast to every mark cell.
	typedef struct packed {
		logic shift;
		logic clr_sent;
		logic clr_ack;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hdl/srsw_cell.sv]
// One window slot: the sent mark and the ack mark of packet base + slot index.
// Uses srsw_pkg::cell_ctl_t; its upper neighbor feeds it when the window slides.
`default_nettype none

module srsw_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire srsw_pkg::cell_ctl_t  ctl,
	input  wire logic                 set_sent,
	input  wire logic                 set_ack,
	input  wire logic                 nxt_sent,
	input  wire logic                 nxt_ack,
	output logic                      sent_q,
	output logic                      ack_q
);

	// Clearing wins over sliding, sliding over marking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= 1'b0;
			ack_q <= 1'b0;
		end else begin
			if (ctl.clr_sent) begin
				sent_q <= 1'b0;
			end else if (ctl.shift) begin
				sent_q <= nxt_sent;
			end else if (set_sent) begin
				sent_q <= 1'b1;
			end
			if (ctl.clr_ack) begin
				ack_q <= 1'b0;
			end else if (ctl.shift) begin
				ack_q <= nxt_ack;
			end else if (set_ack) begin
				ack_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/srsw_div.sv]
// Restoring divider for the congestion cut: window by divisor, one quotient bit per cycle.
// Uses srsw_pkg widths; a zero divisor acts as one.
`default_nettype none

module srsw_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [srsw_pkg::SEQ_W-1:0]       dividend,
	input  wire logic [srsw_pkg::DIVISOR_W-1:0]   divisor,
	output logic                                  done_q,
	output logic [srsw_pkg::SEQ_W-1:0]            quo_q
);

	localparam int CNT_W = $clog2(srsw_pkg::SEQ_W) + 1;

	logic [srsw_pkg::DIVISOR_W-1:0] rem_q;
	logic [srsw_pkg::DIVISOR_W-1:0] div_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           busy_q;
	logic [srsw_pkg::DIVISOR_W:0]   trial;
	logic                           fits;

	assign trial = {rem_q, quo_q[srsw_pkg::SEQ_W-1]};
	assign fits = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(srsw_pkg::SEQ_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= (divisor == '0) ? srsw_pkg::DIVISOR_W'(1) : divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= srsw_pkg::DIVISOR_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[srsw_pkg::DIVISOR_W-1:0];
			end
			quo_q <= {quo_q[srsw_pkg::SEQ_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire

[hdl/selective_repeat_send_window.sv]
// Top level of the selective-repeat send window: sequencer, window registers, row of mark cells.
// Depends on srsw_pkg, srsw_cell and srsw_div.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+-------------------------------------------
//   s_axis    | in        | tvalid / tready      | tuser: func; tdata: seq_number, checksum_ok
//   m_axis    | out       | tvalid / tready      | tdata: accepted, window_start, window_end,
//             |           |                      |        window_size, finished
//   cfg       | in        | cfg_wen, no wait     | cfg_index selects register, cfg_data value
//
// One item is handled at a time. A send, a timeout or a rejected ack goes from the decide state
// to the output state, which loads the result register. An accepted ack first slides the base
// past each leading acked slot (at most WINDOW_SLOTS); congestion runs the bit-serial divider.
// Both then set a new window size and end. A next item can be taken in the cycle after the load.
// Reset clears all marks at once (they live in flip-flops) and loads the register defaults.
// A stalled result holds in the output register; the next item is taken as soon as the
// sequencer is idle again, even while that result still waits.
`default_nettype none

module selective_repeat_send_window #(
	parameter int WINDOW_SLOTS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration writes.
	input  wire logic                                cfg_wen,
	input  wire logic [srsw_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Event items.
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// tdata, lowest bit up: seq_number[15:0], checksum_ok[16], zero pad[23:17]
	input  wire logic [srsw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// tuser: func[1:0]
	input  wire logic [srsw_pkg::IN_USER_W-1:0]      s_axis_tuser,
	// Result items.
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// tdata, lowest bit up: accepted[0], window_start[16:1], window_end[32:17],
	// window_size[48:33], finished[49], zero pad[55:50]
	output logic [srsw_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

	localparam int SW = srsw_pkg::SEQ_W;
	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

	// Configuration registers.
	logic [srsw_pkg::TOTAL_W-1:0]   total_q;
	logic [srsw_pkg::LIMIT_W-1:0]   limit_q;
	logic [srsw_pkg::STEP_W-1:0]    step_q;
	logic [srsw_pkg::DIVISOR_W-1:0] divisor_q;

	// Window state.
	logic [SW-1:0] base_q;
	logic [SW-1:0] last_q;
	logic [SW-1:0] cwnd_q;

	// Latched event.
	srsw_pkg::func_t func_q;
	logic [SW-1:0]   seq_q;
	logic            ck_q;
	logic            acc_q;

	srsw_pkg::state_t state_q, state_d;

	// Mark row.
	srsw_pkg::cell_ctl_t      ctl;
	logic [WINDOW_SLOTS-1:0]  sent_row;
	logic [WINDOW_SLOTS-1:0]  ack_row;
	logic                     do_set_sent;
	logic                     do_set_ack;

	// Divider.
	logic          div_start;
	logic          div_done;
	logic [SW-1:0] div_quo;

	// Event decode.
	logic [SW-1:0]     off;
	logic [SLOT_W-1:0] off_idx;
	logic              seq_ge_base;
	logic              in_slots;
	logic              send_ok;
	logic              ack_ok;
	logic              slide;
	logic              out_load;

	// Window arithmetic.
	logic [SW:0]   grown;
	logic [SW:0]   grown_min;
	logic [SW-1:0] grown_clamped;
	logic [SW-1:0] quo_min;
	logic [SW-1:0] quo_clamped;
	logic [SW:0]   last_sum;
	logic [SW:0]   slot_cap;
	logic [SW:0]   total_cap;
	logic [SW:0]   last_min;

	// -------------------------------------------------------------------------------------
	// Configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= srsw_pkg::TOTAL_W'(1);
			limit_q <= srsw_pkg::LIMIT_W'(10);
			step_q <= srsw_pkg::STEP_W'(1);
			divisor_q <= srsw_pkg::DIVISOR_W'(2);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				srsw_pkg::CFG_PACKET_COUNT:     total_q <= cfg_data;
				srsw_pkg::CFG_SLOW_START_LIMIT: limit_q <= cfg_data;
				srsw_pkg::CFG_INCREASE_STEP:    step_q <= cfg_data[srsw_pkg::STEP_W-1:0];
				srsw_pkg::CFG_DECREASE_DIVISOR: divisor_q <= cfg_data[srsw_pkg::DIVISOR_W-1:0];
			endcase
		end
	end

	// -------------------------------------------------------------------------------------
	// Event decode, all on the latched item. The offset is the slot that seq_number maps to.
	assign off = seq_q - base_q;
	assign off_idx = off[SLOT_W-1:0];
	assign seq_ge_base = seq_q >= base_q;
	assign in_slots = seq_ge_base && ({1'b0, off} < (SW+1)'(WINDOW_SLOTS));
	assign send_ok = in_slots && (seq_q <= last_q) && (seq_q < total_q);
	assign ack_ok = ck_q && in_slots && sent_row[off_idx];

	// The base slides while the oldest slot is acked and the base is in the window and below SEQ_MAX.
	assign slide = ack_row[0] && (base_q <= last_q) && (base_q != srsw_pkg::SEQ_MAX);

	// Window growth on an ack: doubling in slow start, additive from the limit up, then
	// clamped to the packet count and kept at least one.
	always_comb begin
		if (cwnd_q < limit_q) begin
			grown = {cwnd_q, 1'b0};
		end else if (cwnd_q < total_q) begin
			grown = {1'b0, cwnd_q} + (SW+1)'(step_q);
		end else begin
			grown = {1'b0, cwnd_q};
		end
		grown_min = (grown > {1'b0, total_q}) ? {1'b0, total_q} : grown;
		grown_clamped = (grown_min == '0) ? SW'(1) : grown_min[SW-1:0];
		quo_min = (div_quo > total_q) ? total_q : div_quo;
		quo_clamped = (quo_min == '0) ? SW'(1) : quo_min;
	end

	// Window end: base + window - 1, capped at the last packet, the last slot and the top
	// sequence number.
	always_comb begin
		last_sum = {1'b0, base_q} + {1'b0, cwnd_q} - (SW+1)'(1);
		slot_cap = {1'b0, base_q} + (SW+1)'(WINDOW_SLOTS - 1);
		total_cap = (total_q == '0) ? '0 : {1'b0, total_q} - (SW+1)'(1);
		last_min = last_sum;
		if (total_cap < last_min) begin
			last_min = total_cap;
		end
		if (slot_cap < last_min) begin
			last_min = slot_cap;
		end
		if (last_min > {1'b0, srsw_pkg::SEQ_MAX}) begin
			last_min = {1'b0, srsw_pkg::SEQ_MAX};
		end
	end

	// -------------------------------------------------------------------------------------
	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		do_set_sent = 1'b0;
		do_set_ack = 1'b0;
		div_start = 1'b0;
		out_load = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			srsw_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = srsw_pkg::ST_DECIDE;
				end
			end
			srsw_pkg::ST_DECIDE: begin
				unique case (func_q)
					srsw_pkg::FUNC_SENT: begin
						do_set_sent = send_ok;
						state_d = srsw_pkg::ST_OUT;
					end
					srsw_pkg::FUNC_ACK: begin
						do_set_ack = ack_ok;
						state_d = ack_ok ? srsw_pkg::ST_SLIDE : srsw_pkg::ST_OUT;
					end
					srsw_pkg::FUNC_TIMEOUT: begin
						ctl.clr_sent = 1'b1;
						ctl.clr_ack = 1'b1;
						state_d = srsw_pkg::ST_OUT;
					end
					srsw_pkg::FUNC_CONGESTION: begin
						ctl.clr_sent = 1'b1;
						div_start = 1'b1;
						state_d = srsw_pkg::ST_DIV;
					end
				endcase
			end
			srsw_pkg::ST_SLIDE: begin
				if (slide) begin
					ctl.shift = 1'b1;
				end else begin
					state_d = srsw_pkg::ST_GROW;
				end
			end
			srsw_pkg::ST_GROW: begin
				state_d = srsw_pkg::ST_LAST;
			end
			srsw_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = srsw_pkg::ST_LAST;
				end
			end
			srsw_pkg::ST_LAST: begin
				state_d = srsw_pkg::ST_OUT;
			end
			srsw_pkg::ST_OUT: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d = srsw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srsw_pkg::ST_IDLE;
			end
		endcase
	end

	// -------------------------------------------------------------------------------------
	// Window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			last_q <= '0;
			cwnd_q <= SW'(1);
			acc_q <= 1'b0;
		end else begin
			unique case (state_q)
				srsw_pkg::ST_DECIDE: begin
					acc_q <= (func_q == srsw_pkg::FUNC_SENT && send_ok) ||
						(func_q == srsw_pkg::FUNC_ACK && ack_ok);
					if (func_q == srsw_pkg::FUNC_TIMEOUT) begin
						cwnd_q <= SW'(1);
						last_q <= base_q;
					end
				end
				srsw_pkg::ST_SLIDE: begin
					if (slide) begin
						base_q <= base_q + SW'(1);
					end
				end
				srsw_pkg::ST_GROW: begin
					cwnd_q <= grown_clamped;
				end
				srsw_pkg::ST_DIV: begin
					if (div_done) begin
						cwnd_q <= quo_clamped;
					end
				end
				srsw_pkg::ST_LAST: begin
					last_q <= last_min[SW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Item latch.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_q <= srsw_pkg::func_t'(s_axis_tuser[1:0]);
			seq_q <= s_axis_tdata[SW-1:0];
			ck_q <= s_axis_tdata[SW];
		end
	end

	// -------------------------------------------------------------------------------------
	// Row of mark cells; slot i takes slot i+1's marks when the window slides.
	for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
		logic nxt_sent;
		logic nxt_ack;
		if (i == WINDOW_SLOTS - 1) begin : g_top
			assign nxt_sent = 1'b0;
			assign nxt_ack = 1'b0;
		end else begin : g_mid
			assign nxt_sent = sent_row[i+1];
			assign nxt_ack = ack_row[i+1];
		end
		srsw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.set_sent (do_set_sent && (off_idx == SLOT_W'(i))),
			.set_ack  (do_set_ack && (off_idx == SLOT_W'(i))),
			.nxt_sent (nxt_sent),
			.nxt_ack  (nxt_ack),
			.sent_q   (sent_row[i]),
			.ack_q    (ack_row[i])
		);
	end

	srsw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cwnd_q),
		.divisor  (divisor_q),
		.done_q   (div_done),
		.quo_q    (div_quo)
	);

	// -------------------------------------------------------------------------------------
	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {6'd0, base_q >= total_q, cwnd_q, last_q, base_q, acc_q};
		end
	end

endmodule

`default_nettype wire

[hdl/srsw_checker.sv]
// Port-level checks of the send window and the bind that attaches them to the top level.
// Depends only on the top level's ports.
`default_nettype none

module srsw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [55:0] m_axis_tdata
);

	// A result that is not taken stays and keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The window never reads as empty.
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[48:33] != 16'd0)
		else $error("window size of zero");

	// One item at a time: the input closes right after an item is taken.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while busy");

	// Taking an item never makes a fresh result valid straight away.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !(m_axis_tvalid && !$past(m_axis_tvalid)))
		else $error("result without work");

endmodule

bind selective_repeat_send_window srsw_checker u_srsw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[bench/tb_selective_repeat_send_window.sv]
// Self-checking bench for the selective-repeat send window: it predicts each window result in a
// small tracker class and compares every returned item with the oldest prediction.
// Depends on srsw_pkg and the selective_repeat_send_window top level.

module tb_selective_repeat_send_window;

	localparam int SLOTS = 64;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int SW = srsw_pkg::SEQ_W;
	localparam int DW = srsw_pkg::CFG_DATA_W;
	// Cycles without any accepted item before the run is declared hung. The slowest legal gap is
	// the long receiver hold plus a congestion divide and a settle pause.
	localparam int IDLE_LIMIT = 3000;

	// One window result as the block reports it.
	typedef struct packed {
		logic          accepted;
		logic [SW-1:0] win_start;
		logic [SW-1:0] win_end;
		logic [SW-1:0] win_size;
		logic          finished;
	} window_result_t;

	// Tracks the sender window exactly as the block should: configuration, base, last sendable
	// packet, congestion window and the per-slot sent and ack marks (bit i is packet base + i).
	class window_tracker;
		bit [srsw_pkg::TOTAL_W-1:0]   packet_count;
		bit [srsw_pkg::LIMIT_W-1:0]   slow_start_limit;
		bit [srsw_pkg::STEP_W-1:0]    increase_step;
		bit [srsw_pkg::DIVISOR_W-1:0] decrease_divisor;
		bit [SW-1:0]                  base;
		bit [SW-1:0]                  last;
		bit [SW-1:0]                  cwnd;
		bit [SLOTS-1:0]               sent_marks;
		bit [SLOTS-1:0]               ack_marks;
		window_result_t               pending_windows[$];
		int                           bad_results;

		function new();
			packet_count = srsw_pkg::TOTAL_W'(1);
			slow_start_limit = srsw_pkg::LIMIT_W'(10);
			increase_step = srsw_pkg::STEP_W'(1);
			decrease_divisor = srsw_pkg::DIVISOR_W'(2);
			base = '0;
			last = '0;
			cwnd = SW'(1);
			sent_marks = '0;
			ack_marks = '0;
			bad_results = 0;
		endfunction

		function void set_register(logic [srsw_pkg::CFG_INDEX_W-1:0] index,
				logic [DW-1:0] value);
			case (index)
				srsw_pkg::CFG_PACKET_COUNT: packet_count = value;
				srsw_pkg::CFG_SLOW_START_LIMIT: slow_start_limit = value;
				srsw_pkg::CFG_INCREASE_STEP: increase_step = value[srsw_pkg::STEP_W-1:0];
				srsw_pkg::CFG_DECREASE_DIVISOR:
					decrease_divisor = value[srsw_pkg::DIVISOR_W-1:0];
				default: ;
			endcase
		endfunction

		// The window never exceeds the packet count or 16 bits and never drops below one.
		function int unsigned clamp_window(int unsigned w);
			if (w > packet_count) w = packet_count;
			if (w > srsw_pkg::SEQ_MAX) w = srsw_pkg::SEQ_MAX;
			if (w < 1) w = 1;
			return w;
		endfunction

		// Last sendable packet: limited by the window, the final packet and the slot row.
		function void update_last();
			int unsigned top;
			int unsigned cap;
			top = 32'(base) + 32'(cwnd) - 1;
			cap = (packet_count > 0) ? 32'(packet_count) - 1 : 0;
			if (top > cap) top = cap;
			if (top > 32'(base) + SLOTS - 1) top = 32'(base) + SLOTS - 1;
			if (top > srsw_pkg::SEQ_MAX) top = srsw_pkg::SEQ_MAX;
			last = SW'(top);
		endfunction

		function int pending();
			return pending_windows.size();
		endfunction

		// Applies one accepted event and queues the window it should produce.
		function void apply_event(srsw_pkg::func_t func, bit [SW-1:0] seq, bit checksum_ok);
			window_result_t r;
			int unsigned offset;
			logic [SLOT_W-1:0] slot;
			int unsigned grown;
			int unsigned divisor;
			r.accepted = 1'b0;
			// A sequence number below the base wraps to a huge offset and fails the slot test.
			offset = 32'(seq) - 32'(base);
			slot = offset[SLOT_W-1:0];
			case (func)
				srsw_pkg::FUNC_SENT: begin
					if (seq >= base && seq <= last && seq < packet_count && offset < SLOTS) begin
						sent_marks[slot] = 1'b1;
						r.accepted = 1'b1;
					end
				end
				srsw_pkg::FUNC_ACK: begin
					if (checksum_ok && seq >= base && offset < SLOTS && sent_marks[slot]) begin
						ack_marks[slot] = 1'b1;
						r.accepted = 1'b1;
						grown = 32'(cwnd);
						// Slide the base past every leading acked slot.
						while (base <= last && base < srsw_pkg::SEQ_MAX && ack_marks[0]) begin
							sent_marks >>= 1;
							ack_marks >>= 1;
							base++;
						end
						if (grown < slow_start_limit)
							grown = grown * 2;
						else if (grown < packet_count)
							grown = grown + 32'(increase_step);
						cwnd = SW'(clamp_window(grown));
						update_last();
					end
				end
				srsw_pkg::FUNC_TIMEOUT: begin
					sent_marks = '0;
					ack_marks = '0;
					cwnd = SW'(1);
					last = base;
				end
				default: begin
					// Congestion: a zero divisor behaves as one, ack marks survive.
					divisor = (decrease_divisor == 0) ? 1 : 32'(decrease_divisor);
					sent_marks = '0;
					cwnd = SW'(clamp_window(32'(cwnd) / divisor));
					update_last();
				end
			endcase
			r.win_start = base;
			r.win_end = last;
			r.win_size = cwnd;
			r.finished = (base >= packet_count);
			pending_windows = {pending_windows, r};
		endfunction

		function string show(window_result_t r);
			return $sformatf("accepted=%0d start=%0d end=%0d size=%0d finished=%0d",
				r.accepted, r.win_start, r.win_end, r.win_size, r.finished);
		endfunction

		function void compare_window(logic [srsw_pkg::OUT_DATA_W-1:0] data);
			window_result_t seen;
			window_result_t want;
			seen.accepted = data[0];
			seen.win_start = data[16:1];
			seen.win_end = data[32:17];
			seen.win_size = data[48:33];
			seen.finished = data[49];
			if (pending_windows.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("window result with nothing expected: got %s", show(seen));
				return;
			end
			want = pending_windows.pop_front();
			if (seen.accepted !== want.accepted || seen.win_start !== want.win_start ||
					seen.win_end !== want.win_end || seen.win_size !== want.win_size ||
					seen.finished !== want.finished) begin
				bad_results++;
				if (bad_results <= 10)
					$display("window result mismatch: expected %s, got %s", show(want), show(seen));
			end
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_wen = 1'b0;
	logic [srsw_pkg::CFG_INDEX_W-1:0]    cfg_index = srsw_pkg::CFG_PACKET_COUNT;
	logic [DW-1:0]                       cfg_data = '0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [srsw_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
	logic [srsw_pkg::IN_USER_W-1:0]      s_axis_tuser = srsw_pkg::FUNC_SENT;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [srsw_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

	window_tracker tracker;

	// Traffic shaping. The sender and receiver pick their own idle rates; calm turns all idling
	// off for the closing phase.
	bit          calm = 1'b0;
	int unsigned send_gap_pct = 0;
	int unsigned items_sent = 0;

	always #6 clk = ~clk;

	selective_repeat_send_window u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Result side: check each accepted item, then decide the ready for the next cycle. Stalls
	// come in bursts at a rate that changes over the run (0, 6 or 30 percent), so some
	// stretches run with no stalls at all. Once, after 300 results, ready is held low in one hold
	// while the sender keeps offering items, which fills the block and backs up its input.
	int unsigned results_seen = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned stall_pct = 0;
	int unsigned rx_cycles = 0;
	bit          held_once = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				tracker.compare_window(m_axis_tdata);
				results_seen++;
			end
			rx_cycles++;
			if (rx_cycles % 150 == 0) begin
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 6;
					default: stall_pct = 30;
				endcase
			end
			if (!held_once && !calm && results_seen >= 300) begin
				held_once = 1'b1;
				hold_left = 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(1, 13) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Hang detector: any cycle that moves an item on either side restarts the count.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offers one event item; returns in the time step of its acceptance or after a random gap.
	// Valid stays high unless a gap follows, so back-to-back items never toggle valid within one step.
	task automatic send_event(srsw_pkg::func_t func, bit [SW-1:0] seq, bit checksum_ok);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {{(srsw_pkg::IN_DATA_W - SW - 1){1'b0}}, checksum_ok, seq};
		do @(posedge clk); while (!s_axis_tready);
		tracker.apply_event(func, seq, checksum_ok);
		items_sent++;
		if (items_sent % 50 == 0) begin
			case ($urandom_range(2))
				0: send_gap_pct = 0;
				1: send_gap_pct = 8;
				default: send_gap_pct = 40;
			endcase
		end
		if (!calm && $urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Stops offering items and waits until every predicted window has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic put_register(logic [srsw_pkg::CFG_INDEX_W-1:0] index, logic [DW-1:0] value);
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		tracker.set_register(index, value);
	endtask

	// Registers change only with the block idle: every result back, then a short pause.
	task automatic write_config(logic [DW-1:0] total, logic [DW-1:0] limit,
			logic [DW-1:0] step, logic [DW-1:0] divisor);
		drain();
		repeat (8) @(posedge clk);
		cfg_wen <= 1'b1;
		put_register(srsw_pkg::CFG_PACKET_COUNT, total);
		put_register(srsw_pkg::CFG_SLOW_START_LIMIT, limit);
		put_register(srsw_pkg::CFG_INCREASE_STEP, step);
		put_register(srsw_pkg::CFG_DECREASE_DIVISOR, divisor);
		cfg_wen <= 1'b0;
	endtask

	// Packet count that leaves room for the given number of packets past the current base.
	function automatic logic [SW-1:0] room(int unsigned extra);
		int unsigned top;
		top = 32'(tracker.base) + extra;
		return (top > srsw_pkg::SEQ_MAX) ? srsw_pkg::SEQ_MAX : SW'(top);
	endfunction

	// Picks the next event. Most items follow a real transfer: sends inside the window (mostly
	// of unsent slots) and acks of sent slots, now and then with a bad checksum. Timeouts and
	// congestion come in rarely, and the rest is noise near the base or anywhere.
	function automatic void pick_event(output srsw_pkg::func_t func, output bit [SW-1:0] seq,
			output bit checksum_ok);
		int roll;
		int unsigned span;
		int sent_slots[$];
		roll = $urandom_range(99);
		func = srsw_pkg::FUNC_SENT;
		seq = SW'($urandom);
		checksum_ok = 1'b1;
		for (int i = 0; i < SLOTS; i++)
			if (tracker.sent_marks[i]) sent_slots = {sent_slots, i};
		if (roll >= 40 && roll < 78 && sent_slots.size() == 0) roll = 0;
		if (roll < 40) begin
			if (tracker.base <= tracker.last) begin
				span = 32'(tracker.last) - 32'(tracker.base);
				seq = SW'(32'(tracker.base) + $urandom_range(span));
				for (int t = 0; t < 3 && tracker.sent_marks[SLOT_W'(seq - tracker.base)]; t++)
					seq = SW'(32'(tracker.base) + $urandom_range(span));
			end else begin
				seq = SW'(32'(tracker.base) + $urandom_range(3));
			end
		end else if (roll < 78) begin
			func = srsw_pkg::FUNC_ACK;
			seq = SW'(32'(tracker.base) + sent_slots[$urandom_range(sent_slots.size() - 1)]);
			checksum_ok = ($urandom_range(9) != 0);
		end else if (roll < 82) begin
			func = srsw_pkg::FUNC_TIMEOUT;
			checksum_ok = 1'($urandom_range(1));
		end else if (roll < 88) begin
			func = srsw_pkg::FUNC_CONGESTION;
			checksum_ok = 1'($urandom_range(1));
		end else if (roll < 94) begin
			func = srsw_pkg::func_t'($urandom_range(3));
			seq = SW'(32'(tracker.base) + $urandom_range(80) - 8);
			checksum_ok = 1'($urandom_range(1));
		end else begin
			func = srsw_pkg::func_t'($urandom_range(3));
			checksum_ok = 1'($urandom_range(1));
		end
	endfunction

	task automatic run_random(int unsigned count);
		srsw_pkg::func_t func;
		bit [SW-1:0] seq;
		bit checksum_ok;
		repeat (count) begin
			pick_event(func, seq, checksum_ok);
			send_event(func, seq, checksum_ok);
		end
	endtask

	initial begin
		tracker = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, a one-packet transfer: out-of-range send, ack of an unsent slot, a
		// repeated send, a bad checksum, the completing ack, a send once finished, then a
		// timeout and a congestion event.
		send_event(srsw_pkg::FUNC_SENT, srsw_pkg::SEQ_MAX, 1'b0);
		send_event(srsw_pkg::FUNC_ACK, 16'd0, 1'b1);
		send_event(srsw_pkg::FUNC_SENT, 16'd0, 1'b1);
		send_event(srsw_pkg::FUNC_SENT, 16'd0, 1'b0);
		send_event(srsw_pkg::FUNC_ACK, 16'd0, 1'b0);
		send_event(srsw_pkg::FUNC_ACK, 16'd0, 1'b1);
		send_event(srsw_pkg::FUNC_SENT, 16'd1, 1'b1);
		send_event(srsw_pkg::FUNC_TIMEOUT, 16'd0, 1'b0);
		send_event(srsw_pkg::FUNC_CONGESTION, srsw_pkg::SEQ_MAX, 1'b1);

		// Widest settings and a zero divisor: the window doubles past the slot row, where the
		// last sendable packet stops at base plus 63, and congestion leaves it unchanged.
		write_config(srsw_pkg::SEQ_MAX, srsw_pkg::SEQ_MAX, 16'h00FF, 16'h0000);
		send_event(srsw_pkg::FUNC_TIMEOUT, 16'd0, 1'b1);
		repeat (8) begin
			send_event(srsw_pkg::FUNC_SENT, tracker.base, 1'b1);
			send_event(srsw_pkg::FUNC_ACK, tracker.base, 1'b1);
		end
		send_event(srsw_pkg::FUNC_CONGESTION, 16'd0, 1'b0);
		send_event(srsw_pkg::FUNC_ACK, tracker.base + 16'd70, 1'b1);

		// Random phases over a spread of settings.
		write_config(room(400), 16'd8, 16'd1, 16'd2);
		run_random(250);
		write_config(room(150), 16'd1, 16'd255, 16'd255);
		run_random(250);
		write_config(srsw_pkg::SEQ_MAX, srsw_pkg::SEQ_MAX, DW'($urandom_range(1, 255)), 16'd1);
		run_random(250);
		write_config(DW'(32'(tracker.base) + $urandom_range(1, 60)), 16'd0, 16'd0, 16'd0);
		run_random(220);
		// Raw 16-bit values: the 8-bit registers keep only their low bits.
		write_config(DW'($urandom), DW'($urandom), DW'($urandom), DW'($urandom));
		run_random(220);
		// An empty transfer: everything counts as finished and nothing can be sent.
		write_config(16'd0, 16'd10, 16'd1, 16'd2);
		run_random(40);

		// Closing phase with both sides streaming at full rate.
		calm = 1'b1;
		write_config(room(300), 16'd10, 16'd1, 16'd2);
		run_random(230);

		drain();
		repeat (100) @(posedge clk);
		if (tracker.bad_results == 0 && tracker.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
hdl/srsw_pkg.sv
hdl/srsw_cell.sv
hdl/srsw_div.sv
hdl/selective_repeat_send_window.sv
hdl/srsw_checker.sv
bench/tb_selective_repeat_send_window.sv
